// ===== rtl/core/q2e_pkg.sv =====
package q2e_pkg;

  localparam int QuatBits        = 16;
  localparam int AngleBits       = 16;
  localparam int CordicStagesDef = 16;
  localparam int CordicMaxStages = 32;

  localparam int ProdBits  = 2 * QuatBits;
  localparam int TermBits  = ProdBits + 4;
  localparam int FracBits  = 2 * (QuatBits - 2);
  localparam int SineBits  = FracBits + 2;
  localparam int CosBits   = FracBits + 1;
  localparam int SqrtBits  = 2 * FracBits + 1;
  localparam int SqrtIters = FracBits + 1;
  localparam int SqrtLat   = SqrtIters + 1;

  localparam int NormTop    = 40;
  localparam int LzBits     = 6;
  localparam int CorBits    = NormTop + 5;
  localparam int AccBits    = 34;
  localparam int RoundShift = 32 - AngleBits;
  localparam int RoundBits  = AccBits - RoundShift;

  localparam logic signed [TermBits-1:0] OneQ = TermBits'(64'd1 << FracBits);

  typedef struct packed {
    logic signed [QuatBits-1:0] quat_x;
    logic signed [QuatBits-1:0] quat_y;
    logic signed [QuatBits-1:0] quat_z;
    logic signed [QuatBits-1:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic signed [AngleBits-1:0] roll_angle;
    logic signed [AngleBits-1:0] pitch_angle;
    logic signed [AngleBits-1:0] yaw_angle;
    logic                        pitch_clamped;
  } euler_t;

  typedef struct packed {
    logic signed [TermBits-1:0] roll_y;
    logic signed [TermBits-1:0] roll_x;
    logic signed [TermBits-1:0] yaw_y;
    logic signed [TermBits-1:0] yaw_x;
    logic                       clamped;
  } term_t;

  function automatic logic [29:0] atan_entry(input logic [4:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      5'd24: r = 30'd41;
      5'd25: r = 30'd20;
      5'd26: r = 30'd10;
      5'd27: r = 30'd5;
      5'd28: r = 30'd3;
      5'd29: r = 30'd1;
      5'd30: r = 30'd1;
      5'd31: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/quaternion_to_euler.sv =====
// Channel   Direction  Handshake                 Word
// in        input      in_valid_i / in_ready_o   in_data_i  (quat_t)
// out       output     out_valid_o / out_ready_i out_data_o (euler_t)
//
// One word per cycle sustained while the output is taken (out_ready_i high or no word
// waiting); words pass the term products, the 29-step square-root pipeline, then the CORDIC pipeline.
// Reset clears only the valid bits; no warm-up after reset.
// A stalled output freezes every stage at once; nothing is lost or repeated.
module quaternion_to_euler import q2e_pkg::*; #(
  parameter int CordicStages = CordicStagesDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  quat_t  in_data_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output euler_t out_data_o
);

  localparam int AtanLat = CordicStages + 3;

  logic                        en;
  logic                        tv, sv, rv, pv, yv;
  term_t                       terms;
  logic signed [SineBits-1:0]  sine_t, sine_s;
  logic [CosBits-1:0]          cos_s;
  term_t                       dly_q [SqrtLat];
  logic [AtanLat-1:0]          clp_q;
  logic signed [RoundBits-1:0] roll_a, pitch_a, yaw_a;
  logic signed [RoundBits-1:0] pitch_s;

  localparam logic signed [RoundBits-1:0] PitchLim = RoundBits'(1) << (AngleBits - 2);

  assign en         = !pv || out_ready_i;
  assign in_ready_o = en;

  q2e_terms u_terms (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .quat_i  (in_data_i),
    .valid_o (tv),
    .terms_o (terms),
    .sine_o  (sine_t)
  );

  q2e_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tv),
    .sine_i  (sine_t),
    .valid_o (sv),
    .sine_o  (sine_s),
    .cos_o   (cos_s)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_q[0] <= terms;
      for (int k = 1; k < SqrtLat; k++) begin
        dly_q[k] <= dly_q[k-1];
      end
      clp_q <= {clp_q[AtanLat-2:0], dly_q[SqrtLat-1].clamped};
    end
  end

  q2e_atan2 #(.Stages(CordicStages)) u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sv),
    .y_i     (dly_q[SqrtLat-1].roll_y),
    .x_i     (dly_q[SqrtLat-1].roll_x),
    .valid_o (rv),
    .angle_o (roll_a)
  );

  q2e_atan2 #(.Stages(CordicStages)) u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sv),
    .y_i     (TermBits'(sine_s)),
    .x_i     (TermBits'({1'b0, cos_s})),
    .valid_o (pv),
    .angle_o (pitch_a)
  );

  q2e_atan2 #(.Stages(CordicStages)) u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sv),
    .y_i     (dly_q[SqrtLat-1].yaw_y),
    .x_i     (dly_q[SqrtLat-1].yaw_x),
    .valid_o (yv),
    .angle_o (yaw_a)
  );

  always_comb begin
    if (pitch_a > PitchLim) begin
      pitch_s = PitchLim;
    end else if (pitch_a < -PitchLim) begin
      pitch_s = -PitchLim;
    end else begin
      pitch_s = pitch_a;
    end
  end

  assign out_valid_o              = pv;
  assign out_data_o.roll_angle    = AngleBits'(roll_a);
  assign out_data_o.pitch_angle   = AngleBits'(pitch_s);
  assign out_data_o.yaw_angle     = AngleBits'(yaw_a);
  assign out_data_o.pitch_clamped = clp_q[AtanLat-1];

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rv == pv) && (yv == pv))
    else $error("angle lanes out of step");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("pipeline stalled with no word waiting");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pitch_s <= PitchLim) && (pitch_s >= -PitchLim))
    else $error("pitch out of range");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(pitch_a) && $stable(roll_a) && $stable(yaw_a))
    else $error("angles moved during stall");

endmodule

// ===== rtl/core/q2e_terms.sv =====
module q2e_terms import q2e_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  quat_t                      quat_i,
  output logic                       valid_o,
  output term_t                      terms_o,
  output logic signed [SineBits-1:0] sine_o
);

  logic signed [ProdBits-1:0] wx_q, yz_q, xx_q, yy_q, wy_q, zx_q, wz_q, xy_q, zz_q;
  logic                       v1_q, v2_q;
  term_t                      terms_d, terms_q;
  logic signed [SineBits-1:0] sine_d, sine_q;
  logic signed [TermBits-1:0] t2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wx_q <= quat_i.quat_w * quat_i.quat_x;
      yz_q <= quat_i.quat_y * quat_i.quat_z;
      xx_q <= quat_i.quat_x * quat_i.quat_x;
      yy_q <= quat_i.quat_y * quat_i.quat_y;
      wy_q <= quat_i.quat_w * quat_i.quat_y;
      zx_q <= quat_i.quat_z * quat_i.quat_x;
      wz_q <= quat_i.quat_w * quat_i.quat_z;
      xy_q <= quat_i.quat_x * quat_i.quat_y;
      zz_q <= quat_i.quat_z * quat_i.quat_z;
      terms_q <= terms_d;
      sine_q  <= sine_d;
    end
  end

  always_comb begin
    terms_d.roll_y = (TermBits'(wx_q) + TermBits'(yz_q)) <<< 1;
    terms_d.roll_x = OneQ - ((TermBits'(xx_q) + TermBits'(yy_q)) <<< 1);
    terms_d.yaw_y  = (TermBits'(wz_q) + TermBits'(xy_q)) <<< 1;
    terms_d.yaw_x  = OneQ - ((TermBits'(yy_q) + TermBits'(zz_q)) <<< 1);
    t2 = (TermBits'(wy_q) - TermBits'(zx_q)) <<< 1;
    if (t2 > OneQ) begin
      sine_d          = SineBits'(OneQ);
      terms_d.clamped = 1'b1;
    end else if (t2 < -OneQ) begin
      sine_d          = SineBits'(-OneQ);
      terms_d.clamped = 1'b1;
    end else begin
      sine_d          = SineBits'(t2);
      terms_d.clamped = 1'b0;
    end
  end

  assign valid_o = v2_q;
  assign terms_o = terms_q;
  assign sine_o  = sine_q;

endmodule

// ===== rtl/core/q2e_sqrt.sv =====
module q2e_sqrt import q2e_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic signed [SineBits-1:0] sine_i,
  output logic                       valid_o,
  output logic signed [SineBits-1:0] sine_o,
  output logic        [CosBits-1:0]  cos_o
);

  logic [SqrtBits-1:0]        rem_q  [SqrtLat];
  logic [SqrtBits-1:0]        root_q [SqrtLat];
  logic signed [SineBits-1:0] sine_q [SqrtLat];
  logic [SqrtLat-1:0]         vld_q;

  logic signed [SineBits-1:0] mag;
  logic [2*CosBits-1:0]       sq;
  logic [2*CosBits-1:0]       rad;

  always_comb begin
    mag = (sine_i < 0) ? -sine_i : sine_i;
    sq  = CosBits'(mag) * CosBits'(mag);
    rad = ((2*CosBits)'(1) << (2*FracBits)) - sq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[SqrtLat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= SqrtBits'(rad);
      root_q[0] <= '0;
      sine_q[0] <= sine_i;
    end
  end

  for (genvar j = 1; j < SqrtLat; j++) begin : g_iter
    localparam logic [SqrtBits:0] Bit = (SqrtBits+1)'(1) << (2*(SqrtIters-j));
    logic [SqrtBits:0] trial;

    always_comb trial = {1'b0, root_q[j-1]} + Bit;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sine_q[j] <= sine_q[j-1];
        if ({1'b0, rem_q[j-1]} >= trial) begin
          rem_q[j]  <= rem_q[j-1] - SqrtBits'(trial);
          root_q[j] <= SqrtBits'(({1'b0, root_q[j-1]} >> 1) + Bit);
        end else begin
          rem_q[j]  <= rem_q[j-1];
          root_q[j] <= root_q[j-1] >> 1;
        end
      end
    end
  end

  assign valid_o = vld_q[SqrtLat-1];
  assign sine_o  = sine_q[SqrtLat-1];
  assign cos_o   = CosBits'(root_q[SqrtLat-1]);

endmodule

// ===== rtl/core/q2e_atan2.sv =====
module q2e_atan2 import q2e_pkg::*; #(
  parameter int Stages = CordicStagesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic signed [TermBits-1:0]  y_i,
  input  logic signed [TermBits-1:0]  x_i,
  output logic                        valid_o,
  output logic signed [RoundBits-1:0] angle_o
);

  logic [TermBits-1:0]        ax, ay, mag;
  logic [LzBits-1:0]          msb;
  logic signed [TermBits-1:0] xa_q, ya_q;
  logic [LzBits-1:0]          sh_q;
  logic                       za_q;

  logic signed [CorBits-1:0]  xs, ys, x0, y0;
  logic signed [AccBits-1:0]  a0;

  logic signed [CorBits-1:0]  cx_q [Stages+1];
  logic signed [CorBits-1:0]  cy_q [Stages+1];
  logic signed [AccBits-1:0]  ca_q [Stages+1];
  logic                       cz_q [Stages+1];

  logic signed [AccBits-1:0]   rsum;
  logic signed [RoundBits-1:0] angle_q;
  logic [Stages+2:0]           vld_q;

  always_comb begin
    ax  = (x_i < 0) ? -x_i : x_i;
    ay  = (y_i < 0) ? -y_i : y_i;
    mag = ax | ay;
    msb = '0;
    for (int b = 0; b < TermBits; b++) begin
      if (mag[b]) msb = LzBits'(b);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Stages+1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xa_q <= x_i;
      ya_q <= y_i;
      sh_q <= LzBits'(NormTop) - msb;
      za_q <= (mag == '0);
    end
  end

  always_comb begin
    xs = CorBits'(xa_q) <<< sh_q;
    ys = CorBits'(ya_q) <<< sh_q;
    x0 = xs;
    y0 = ys;
    a0 = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        x0 = ys;
        y0 = -xs;
        a0 = AccBits'(1) << 30;
      end else begin
        x0 = -ys;
        y0 = xs;
        a0 = -(AccBits'(1) << 30);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q[0] <= x0;
      cy_q[0] <= y0;
      ca_q[0] <= a0;
      cz_q[0] <= za_q;
    end
  end

  for (genvar i = 0; i < Stages; i++) begin : g_cordic
    localparam logic [AccBits-1:0] Step = AccBits'(atan_entry(5'(i)));
    logic signed [CorBits-1:0] dx, dy;

    always_comb begin
      dx = cy_q[i] >>> i;
      dy = cx_q[i] >>> i;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cz_q[i+1] <= cz_q[i];
        if (cy_q[i] >= 0) begin
          cx_q[i+1] <= cx_q[i] + dx;
          cy_q[i+1] <= cy_q[i] - dy;
          ca_q[i+1] <= ca_q[i] + $signed(Step);
        end else begin
          cx_q[i+1] <= cx_q[i] - dx;
          cy_q[i+1] <= cy_q[i] + dy;
          ca_q[i+1] <= ca_q[i] - $signed(Step);
        end
      end
    end
  end

  always_comb rsum = ca_q[Stages] + (AccBits'(1) << (RoundShift - 1));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= cz_q[Stages] ? '0 : RoundBits'(rsum >>> RoundShift);
    end
  end

  assign valid_o = vld_q[Stages+2];
  assign angle_o = angle_q;

endmodule
